// File: rtl/core/ghb_pkg.sv
`default_nettype none
package ghb_pkg;

    localparam int MAX_BINS    = 32;
    localparam int MAX_GROUPS  = 512;
    localparam int COUNT_BITS  = 16;

    localparam int BIN_BITS    = $clog2(MAX_BINS);
    localparam int GROUP_W     = 9;
    localparam int ADDR_BITS   = GROUP_W + BIN_BITS;
    localparam int STORE_DEPTH = MAX_GROUPS * MAX_BINS;

    // field widths of the stream payloads
    localparam int VALUE_W     = 32;
    localparam int BIN_W       = 5;
    localparam int COUNT_W     = 16;
    localparam int NB_W        = 6;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int S_TDATA_W   = 56;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 24;

    localparam int QUEUE_DEPTH = 4;
    localparam int QP_BITS     = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_SELECT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_EDGE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_BIN_WIDTH = 2'd3;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_RMW
    } t_bstate;

    typedef struct packed {
        t_cmd                 cmd;
        logic [ADDR_BITS-1:0] addr;
        logic [BIN_W-1:0]     bin;
        logic                 hit;
    } t_job;

    typedef struct packed {
        logic [COUNT_W-1:0] count_value;
        logic [BIN_W-1:0]   bin_index;
        logic               in_range;
        logic               saturated;
    } t_result;

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

endpackage
`default_nettype wire

// File: rtl/core/ghb_front.sv
`default_nettype none
module ghb_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [ghb_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  wire logic [ghb_pkg::S_TUSER_W-1:0]   i_s_tuser,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [ghb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ghb_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire ghb_pkg::t_back_stat             i_back_stat,
    output logic                                 o_push,
    output ghb_pkg::t_job                        o_job,
    input  wire logic                            i_full
);
    import ghb_pkg::*;

    logic                    r_axis_select;
    logic [NB_W-1:0]         r_num_bins;
    logic [VALUE_W-1:0]      r_low_edge;
    logic [VALUE_W-1:0]      r_inv_bin_width;

    logic                    r1_vld;
    t_cmd                    r1_cmd;
    logic                    r1_neg;
    logic [VALUE_W-1:0]      r1_mag;
    logic [GROUP_W-1:0]      r1_group;
    logic [BIN_W-1:0]        r1_sel;

    logic                    r2_vld;
    t_cmd                    r2_cmd;
    logic                    r2_neg;
    logic [2*VALUE_W-1:0]    r2_prod;
    logic [GROUP_W-1:0]      r2_group;
    logic [BIN_W-1:0]        r2_sel;

    logic                    s_acc;
    logic                    s1_move;
    logic                    s2_take;
    logic [VALUE_W:0]        diff_pos;
    logic [VALUE_W:0]        diff_neg;
    logic [VALUE_W-1:0]      in_value;
    logic [GROUP_W-1:0]      in_group;
    logic [VALUE_W-1:0]      q;
    logic [NB_W-1:0]         nb_use;
    logic                    group_ok;
    logic                    add_ok;
    logic                    read_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_select   <= 1'b0;
            r_num_bins      <= NB_W'(32);
            r_low_edge      <= '0;
            r_inv_bin_width <= VALUE_W'(65536);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_AXIS_SELECT:   r_axis_select   <= i_cfg_data[0];
                CFG_NUM_BINS:      r_num_bins      <= i_cfg_data[NB_W-1:0];
                CFG_LOW_EDGE:      r_low_edge      <= i_cfg_data[VALUE_W-1:0];
                CFG_INV_BIN_WIDTH: r_inv_bin_width <= i_cfg_data[VALUE_W-1:0];
            endcase
        end
    end

    // stage handshake: the product stage drains into the queue
    assign o_push     = r2_vld && !i_full;
    assign s2_take    = !r2_vld || o_push;
    assign s1_move    = r1_vld && s2_take;
    assign o_s_tready = (!r1_vld || s1_move) && !i_back_stat.init_busy;
    assign s_acc      = i_s_tvalid && o_s_tready;

    // both differences in parallel, pick the magnitude by the sign
    always_comb begin
        in_value = i_s_tdata[VALUE_W-1:0];
        in_group = r_axis_select ? i_s_tdata[VALUE_W +: GROUP_W]
                                 : i_s_tdata[VALUE_W+GROUP_W +: GROUP_W];
        diff_pos = {in_value[VALUE_W-1], in_value} - {r_low_edge[VALUE_W-1], r_low_edge};
        diff_neg = {r_low_edge[VALUE_W-1], r_low_edge} - {in_value[VALUE_W-1], in_value};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (s_acc) begin
            r1_vld <= 1'b1;
        end else if (s1_move) begin
            r1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r1_cmd   <= t_cmd'(i_s_tuser);
            r1_neg   <= diff_pos[VALUE_W];
            r1_mag   <= diff_pos[VALUE_W] ? diff_neg[VALUE_W-1:0] : diff_pos[VALUE_W-1:0];
            r1_group <= in_group;
            r1_sel   <= i_s_tdata[VALUE_W+2*GROUP_W +: BIN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (s1_move) begin
            r2_vld <= 1'b1;
        end else if (o_push) begin
            r2_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r2_cmd   <= r1_cmd;
            r2_neg   <= r1_neg;
            r2_prod  <= r1_mag * r_inv_bin_width;
            r2_group <= r1_group;
            r2_sel   <= r1_sel;
        end
    end

    // classify: integer part of the product is the bin, truncated toward zero
    always_comb begin
        q        = r2_prod[2*VALUE_W-1:VALUE_W];
        nb_use   = (r_num_bins < NB_W'(MAX_BINS)) ? r_num_bins : NB_W'(MAX_BINS);
        group_ok = 32'(r2_group) < 32'(MAX_GROUPS);
        add_ok   = (!r2_neg || q == '0) && (q < VALUE_W'(nb_use)) && group_ok;
        read_ok  = (NB_W'(r2_sel) < nb_use) && group_ok;

        o_job.cmd  = r2_cmd;
        o_job.addr = {r2_group, q[BIN_BITS-1:0]};
        o_job.bin  = '0;
        o_job.hit  = 1'b0;
        unique case (r2_cmd)
            CMD_ADD: begin
                o_job.hit = add_ok;
                o_job.bin = add_ok ? q[BIN_W-1:0] : '0;
            end
            CMD_READ: begin
                o_job.hit  = read_ok;
                o_job.bin  = r2_sel;
                o_job.addr = {r2_group, r2_sel[BIN_BITS-1:0]};
            end
            CMD_CLEAR, CMD_NONE: begin
                o_job.hit = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/ghb_queue.sv
`default_nettype none
module ghb_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ghb_pkg::t_job i_job,
    input  wire logic          i_pop,
    output ghb_pkg::t_job      o_job,
    output logic               o_full,
    output logic               o_empty
);
    import ghb_pkg::*;

    t_job                r_slot [QUEUE_DEPTH];
    logic [QP_BITS-1:0]  r_wr_ptr;
    logic [QP_BITS-1:0]  r_rd_ptr;
    logic [QP_BITS:0]    r_level;

    assign o_full  = r_level == (QP_BITS+1)'(QUEUE_DEPTH);
    assign o_empty = r_level == '0;
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (i_pop && !i_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/ghb_back.sv
`default_nettype none
module ghb_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ghb_pkg::t_job i_job,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_res_vld,
    output ghb_pkg::t_result   o_result,
    input  wire logic          i_res_ready,
    output ghb_pkg::t_back_stat o_stat
);
    import ghb_pkg::*;

    logic [COUNT_BITS-1:0] r_store [STORE_DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;

    t_bstate               r_state;
    t_bstate               n_state;
    logic [ADDR_BITS-1:0]  r_clr_cnt;
    logic                  r_clr_cmd;
    t_job                  r_job;
    logic                  r_out_vld;
    t_result               r_result;

    logic                  out_free;
    logic                  clr_last;
    logic                  job_rmw;
    logic                  mem_we;
    logic                  mem_re;
    logic [ADDR_BITS-1:0]  mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  res_load;
    t_result               res_n;
    logic                  sat;
    logic [COUNT_BITS-1:0] inc;

    assign out_free = !r_out_vld || i_res_ready;
    assign clr_last = r_clr_cnt == ADDR_BITS'(STORE_DEPTH - 1);
    assign job_rmw  = (i_job.cmd == CMD_ADD || i_job.cmd == CMD_READ) && i_job.hit;
    assign sat      = r_rd_data == COUNT_MAX;
    assign inc      = sat ? r_rd_data : r_rd_data + 1'b1;

    assign o_res_vld       = r_out_vld;
    assign o_result        = r_result;
    assign o_stat.init_busy = (r_state == BS_CLEAR) && !r_clr_cmd;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_CLEAR: begin
                if (clr_last) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (o_pop) begin
                    if (i_job.cmd == CMD_CLEAR) begin
                        n_state = BS_CLEAR;
                    end else if (job_rmw) begin
                        n_state = BS_RMW;
                    end
                end
            end
            BS_RMW: begin
                n_state = BS_IDLE;
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_clr_cnt;
        mem_wdata = '0;
        res_load  = 1'b0;
        res_n     = '0;
        unique case (r_state)
            BS_CLEAR: begin
                mem_we   = 1'b1;
                res_load = clr_last && r_clr_cmd;
            end
            BS_IDLE: begin
                o_pop = !i_empty && out_free;
                if (o_pop && i_job.cmd != CMD_CLEAR) begin
                    if (job_rmw) begin
                        mem_re = 1'b1;
                    end else begin
                        // dropped sample, invalid read or unused command
                        res_load        = 1'b1;
                        res_n.bin_index = i_job.bin;
                    end
                end
            end
            BS_RMW: begin
                if (r_job.cmd == CMD_ADD) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_job.addr;
                    mem_wdata = inc;
                end
                res_load          = 1'b1;
                res_n.count_value = (r_job.cmd == CMD_ADD) ? COUNT_W'(inc)
                                                           : COUNT_W'(r_rd_data);
                res_n.bin_index   = r_job.bin;
                res_n.in_range    = 1'b1;
                res_n.saturated   = sat;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_CLEAR;
            r_clr_cnt <= '0;
            r_clr_cmd <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end else if (o_pop && i_job.cmd == CMD_CLEAR) begin
                r_clr_cnt <= '0;
                r_clr_cmd <= 1'b1;
            end
            if (res_load) begin
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (res_load) begin
            r_result <= res_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_store[i_job.addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/grouped_histogram_binner.sv
`default_nettype none
// Per-group histogram engine over a count memory of MAX_GROUPS x MAX_BINS entries.
// After reset the count memory is swept to zero, one entry per cycle, and
// s_axis_tready stays low until the sweep is done. The front end computes the bin
// in two pipeline stages (difference, then 32x32 product) and hands jobs to a
// four-entry queue; the back end works one job at a time against the single-port
// count memory: an add or a valid read first reads the count, then writes back the
// increment (add only) and loads the result; a dropped sample, invalid read or
// unused command loads its result as it is taken; a clear command is taken, then
// the 16384-entry sweep runs. The read-modify-write on the count memory keeps the
// back end from taking a new add before the last one is written back.
module grouped_histogram_binner (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // s_axis_tdata: sample_value[31:0], row_index[40:32], col_index[49:41],
    //               bin_select[54:50], zero pad [55]
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [ghb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // s_axis_tuser: cmd[1:0]
    input  wire logic [ghb_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // m_axis_tdata: count_value[15:0], bin_index[20:16], in_range[21],
    //               saturated[22], zero pad [23]
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [ghb_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [ghb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ghb_pkg::CFG_W-1:0]     i_cfg_data
);
    import ghb_pkg::*;

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    t_job       push_job;
    t_job       head_job;
    t_result    result;
    t_back_stat back_stat;

    ghb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_back_stat (back_stat),
        .o_push      (q_push),
        .o_job       (push_job),
        .i_full      (q_full)
    );

    ghb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ghb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_res_vld   (m_axis_tvalid),
        .o_result    (result),
        .i_res_ready (m_axis_tready),
        .o_stat      (back_stat)
    );

    assign m_axis_tdata = {1'b0, result.saturated, result.in_range,
                           result.bin_index, result.count_value};

    // no new samples while the reset sweep owns the count memory
    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.init_busy |-> !s_axis_tready)
        else $error("input taken during count memory sweep");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && q_empty) && !(q_pop && q_empty) && !(q_push && q_full))
        else $error("job queue over or underflow");

    a_sat_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && result.saturated |->
            result.in_range && result.count_value == COUNT_W'(COUNT_MAX))
        else $error("saturated result without a full count");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !result.in_range |->
            result.count_value == '0 && !result.saturated)
        else $error("dropped transaction carries a count");

endmodule
`default_nettype wire

// File: tb/grouped_histogram_binner_tb.sv
`default_nettype none
module grouped_histogram_binner_tb;
    import ghb_pkg::*;

    // clear and the power-up sweep each run over the whole count memory
    localparam int STALL_LIMIT   = 60000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 163;
    localparam int REPEAT_ADDS   = 40;

    typedef struct {
        t_cmd               cmd;
        logic signed [31:0] value;
        logic [8:0]         row;
        logic [8:0]         col;
        logic [4:0]         sel;
        bit                 hold;
    } t_sample_txn;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // shadow of the block's registers and count memory
    logic               cfg_axis = 1'b0;
    logic [NB_W-1:0]    cfg_num_bins = 6'd32;
    logic signed [31:0] cfg_low_edge = '0;
    logic [31:0]        cfg_inv_width = 32'd65536;
    logic [COUNT_W-1:0] hist_counts [STORE_DEPTH] = '{default: '0};

    t_sample_txn sample_queue[$];
    t_sample_txn sample_in_flight;
    t_result     count_results_due[$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int n_errors = 0;
    int quiet_cycles = 0;

    grouped_histogram_binner u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int bins_in_use();
        return (cfg_num_bins < MAX_BINS) ? int'(cfg_num_bins) : MAX_BINS;
    endfunction

    // Apply one command to the shadow memory and return the result it produces.
    function automatic t_result apply_histogram_cmd(input t_sample_txn txn);
        t_result            res;
        logic [8:0]         grp;
        int                 nb;
        logic signed [33:0] diff;
        logic [32:0]        mag;
        logic [64:0]        prod;
        logic [32:0]        q;
        logic [13:0]        addr;
        logic [COUNT_W-1:0] cnt;
        res = '0;
        grp = cfg_axis ? txn.row : txn.col;
        nb = bins_in_use();
        case (txn.cmd)
            CMD_CLEAR: begin
                foreach (hist_counts[i]) hist_counts[i] = '0;
            end
            CMD_ADD: begin
                diff = {{2{txn.value[31]}}, txn.value} - {{2{cfg_low_edge[31]}}, cfg_low_edge};
                mag = diff[33] ? 33'(-diff) : diff[32:0];
                prod = mag * cfg_inv_width;
                // magnitude shifted, sign checked below: truncation toward zero
                q = prod[64:32];
                if (!((diff[33] && q != 0) || q >= 33'(nb))) begin
                    addr = {grp, q[4:0]};
                    cnt = hist_counts[addr];
                    if (cnt == COUNT_MAX) begin
                        res.saturated = 1'b1;
                    end else begin
                        cnt = cnt + 1'b1;
                    end
                    hist_counts[addr] = cnt;
                    res.count_value = cnt;
                    res.bin_index = q[4:0];
                    res.in_range = 1'b1;
                end
            end
            CMD_READ: begin
                res.bin_index = txn.sel;
                if (int'(txn.sel) < nb) begin
                    cnt = hist_counts[{grp, txn.sel}];
                    res.count_value = cnt;
                    res.in_range = 1'b1;
                    res.saturated = (cnt == COUNT_MAX);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_sample_txn make_txn(input t_cmd cmd, input logic [31:0] value,
                                             input logic [8:0] row, input logic [8:0] col,
                                             input logic [4:0] sel);
        t_sample_txn txn;
        txn.cmd = cmd;
        txn.value = value;
        txn.row = row;
        txn.col = col;
        txn.sel = sel;
        txn.hold = 1'b0;
        return txn;
    endfunction

    // Mostly a few groups so counts build up, sometimes the whole index range.
    function automatic logic [8:0] pick_index();
        return ($urandom_range(99) < 85) ? 9'($urandom_range(3)) : 9'($urandom_range(511));
    endfunction

    // Sample value that lands in or next to the given bin under the current setting.
    function automatic logic [31:0] value_near_bin(input int target);
        logic [63:0] num;
        logic [63:0] offs;
        if (cfg_inv_width == 0)
            return $urandom;
        num = (64'(target) << 32) | 64'($urandom);
        offs = num / cfg_inv_width;
        return cfg_low_edge + offs[31:0];
    endfunction

    function automatic t_sample_txn draw_sample();
        t_sample_txn txn;
        int          roll;
        int          nb;
        int          target;
        nb = bins_in_use();
        roll = $urandom_range(999);
        txn = make_txn(CMD_READ, $urandom, pick_index(), pick_index(), 5'($urandom_range(31)));
        txn.hold = ($urandom_range(99) == 0);
        if (roll < 7) begin
            txn.cmd = CMD_CLEAR;
        end else if (roll < 45) begin
            txn.cmd = CMD_NONE;
        end else if (roll < 500) begin
            txn.cmd = CMD_ADD;
            target = (nb == 0) ? 0 : $urandom_range(nb - 1);
            if ($urandom_range(9) == 0)
                target = nb;
            txn.value = value_near_bin(target);
        end else if (roll < 620) begin
            txn.cmd = CMD_ADD;
        end else if ($urandom_range(3) != 0 && nb > 0) begin
            txn.sel = 5'($urandom_range(nb - 1));
        end
        return txn;
    endfunction

    // Driver: present queued samples, predict each one at its handshake.
    always @(posedge i_clk) begin
        bit issue;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                count_results_due.push_back(apply_histogram_cmd(sample_in_flight));
            if (!s_axis_tvalid || s_axis_tready) begin
                issue = 1'b0;
                if (sample_queue.size() != 0) begin
                    issue = ($urandom_range(99) >= src_idle_pct);
                    // hold until the block has delivered everything outstanding
                    if (sample_queue[0].hold && count_results_due.size() != 0)
                        issue = 1'b0;
                end
                if (issue) begin
                    sample_in_flight = sample_queue.pop_front();
                    s_axis_tdata <= {1'b0, sample_in_flight.sel, sample_in_flight.col,
                                     sample_in_flight.row, sample_in_flight.value};
                    s_axis_tuser <= sample_in_flight.cmd;
                end
                s_axis_tvalid <= issue;
            end
        end
    end

    // Monitor: check each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (count_results_due.size() == 0) begin
                    $error("unexpected result transaction, tdata %h", m_axis_tdata);
                    n_errors++;
                end else begin
                    exp_r = count_results_due.pop_front();
                    if (m_axis_tdata[15:0] !== exp_r.count_value) begin
                        $error("count_value mismatch: expected %0d, actual %0d",
                               exp_r.count_value, m_axis_tdata[15:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[20:16] !== exp_r.bin_index) begin
                        $error("bin_index mismatch: expected %0d, actual %0d",
                               exp_r.bin_index, m_axis_tdata[20:16]);
                        n_errors++;
                    end
                    if (m_axis_tdata[21] !== exp_r.in_range) begin
                        $error("in_range mismatch: expected %0d, actual %0d",
                               exp_r.in_range, m_axis_tdata[21]);
                        n_errors++;
                    end
                    if (m_axis_tdata[22] !== exp_r.saturated) begin
                        $error("saturated mismatch: expected %0d, actual %0d",
                               exp_r.saturated, m_axis_tdata[22]);
                        n_errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: quiet stretches longer than a clear sweep mean the block hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (sample_queue.size() != 0 || count_results_due.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_config(input logic axis, input logic [NB_W-1:0] nb,
                                input logic [31:0] low, input logic [31:0] inv);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_AXIS_SELECT;
        i_cfg_data <= 32'(axis);
        @(posedge i_clk);
        i_cfg_index <= CFG_NUM_BINS;
        i_cfg_data <= 32'(nb);
        @(posedge i_clk);
        i_cfg_index <= CFG_LOW_EDGE;
        i_cfg_data <= low;
        @(posedge i_clk);
        i_cfg_index <= CFG_INV_BIN_WIDTH;
        i_cfg_data <= inv;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_axis = axis;
        cfg_num_bins = nb;
        cfg_low_edge = low;
        cfg_inv_width = inv;
    endtask

    initial begin
        logic            axis_set [RANDOM_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1};
        logic [NB_W-1:0] nb_set   [RANDOM_PHASES] = '{32, 16, 1, 63, 0, 32, 33, 8};
        logic [31:0]     low_set  [RANDOM_PHASES] = '{32'h0, 32'hFFFB_0000, 32'h0,
                                                      32'h8000_0000, 32'h0, 32'h7FFF_FFFF,
                                                      32'h0001_0000, 32'hFFFF_0000};
        logic [31:0]     inv_set  [RANDOM_PHASES] = '{32'h0001_0000, 32'h0002_0000,
                                                      32'h0001_0000, 32'hFFFF_FFFF,
                                                      32'h0001_0000, 32'h0,
                                                      32'h0000_1000, 32'h0040_0000};
        int src_pct  [4] = '{0, 61, 0, 7};
        int sink_pct [4] = '{0, 0, 61, 7};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register reset values: group by column, 32 bins of one unit from zero
        sample_queue.push_back(make_txn(CMD_READ, 32'h0, 9'd0, 9'd0, 5'd0));
        sample_queue.push_back(make_txn(CMD_ADD, 32'h0000_0000, 9'd0, 9'd0, 5'd0));
        sample_queue.push_back(make_txn(CMD_ADD, 32'h001F_FFFF, 9'd0, 9'd0, 5'd0));
        sample_queue.push_back(make_txn(CMD_ADD, 32'h0020_0000, 9'd0, 9'd0, 5'd0));
        // less than one bin below the edge truncates into bin zero
        sample_queue.push_back(make_txn(CMD_ADD, 32'hFFFF_8000, 9'd0, 9'd0, 5'd0));
        sample_queue.push_back(make_txn(CMD_ADD, 32'hFFFF_0000, 9'd0, 9'd0, 5'd0));
        sample_queue.push_back(make_txn(CMD_ADD, 32'h7FFF_FFFF, 9'd0, 9'd0, 5'd0));
        sample_queue.push_back(make_txn(CMD_ADD, 32'h8000_0000, 9'd0, 9'd0, 5'd0));
        sample_queue.push_back(make_txn(CMD_ADD, 32'h0005_0000, 9'd0, 9'd511, 5'd0));
        sample_queue.push_back(make_txn(CMD_READ, 32'h0, 9'd0, 9'd511, 5'd5));
        sample_queue.push_back(make_txn(CMD_READ, 32'hFFFF_FFFF, 9'd511, 9'd0, 5'd31));
        sample_queue.push_back(make_txn(CMD_NONE, 32'hFFFF_FFFF, 9'd511, 9'd511, 5'd31));
        sample_queue.push_back(make_txn(CMD_CLEAR, 32'hFFFF_FFFF, 9'd511, 9'd511, 5'd31));
        sample_queue.push_back(make_txn(CMD_READ, 32'h0, 9'd0, 9'd0, 5'd0));
        sample_queue.push_back(make_txn(CMD_ADD, 32'h0001_0000, 9'd511, 9'd0, 5'd0));
        sample_queue.push_back(make_txn(CMD_READ, 32'h0, 9'd0, 9'd0, 5'd1));
        wait_drained();

        // group by row, only four bins
        write_config(1'b1, 6'd4, 32'h0, 32'h0001_0000);
        sample_queue.push_back(make_txn(CMD_ADD, 32'h0003_8000, 9'd3, 9'd200, 5'd0));
        sample_queue.push_back(make_txn(CMD_READ, 32'h0, 9'd3, 9'd9, 5'd3));
        sample_queue.push_back(make_txn(CMD_READ, 32'h0, 9'd3, 9'd9, 5'd4));
        sample_queue.push_back(make_txn(CMD_ADD, 32'h0004_0000, 9'd3, 9'd9, 5'd0));
        wait_drained();

        // stack back-to-back adds on one count
        write_config(1'b0, 6'd32, 32'h0, 32'h0001_0000);
        sample_queue.push_back(make_txn(CMD_CLEAR, 32'h0, 9'd0, 9'd0, 5'd0));
        repeat (REPEAT_ADDS)
            sample_queue.push_back(make_txn(CMD_ADD, 32'h0003_4000, 9'd1, 9'd7, 5'd0));
        sample_queue.push_back(make_txn(CMD_READ, 32'h0, 9'd1, 9'd7, 5'd3));
        sample_queue.push_back(make_txn(CMD_READ, 32'h0, 9'd1, 9'd7, 5'd2));
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_config(axis_set[ph], nb_set[ph], low_set[ph], inv_set[ph]);
            src_idle_pct = src_pct[ph % 4];
            sink_stall_pct = sink_pct[ph % 4];
            repeat (PHASE_ITEMS)
                sample_queue.push_back(draw_sample());
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
